/* hw/rtl/rgbup_pkg.sv */
// ----------------------------------------------------------------------------
// rgbup_pkg
// Types, constants and helpers shared by the RGB565 2.5x upscaler.
// ----------------------------------------------------------------------------
package rgbup_pkg;

	localparam int OUT_LINES       = 480;
	localparam int GROUPS_PER_LINE = 80;

	// fixed field widths of the stream and register
	localparam int PIX_W    = 16;
	localparam int WORD_W   = 32;
	localparam int FIELD_W  = 9;
	localparam int HEIGHT_W = 9;
	localparam int IN_W     = 4 * PIX_W;
	localparam int OUT_W    = 64;
	localparam int USER_W   = 2;

	localparam int NUM_WORDS = 5;
	localparam int WCNT_W    = 3;
	localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(NUM_WORDS - 1);

	localparam int LINE_W  = (OUT_LINES > 1) ? $clog2(OUT_LINES) : 1;
	localparam int GROUP_W = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;
	localparam int SUM_W   = ((LINE_W > HEIGHT_W) ? LINE_W : HEIGHT_W) + 1;

	localparam logic [PIX_W-1:0] PIX_MASK = 16'hF7DE;

	// APB map: 32-bit data bus; only word address 0 holds a register
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_SOURCE_HEIGHT = 1'b0;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(240);

	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] word_vec_t;

	typedef struct packed {
		logic [FIELD_W-1:0] line;
		logic [FIELD_W-1:0] base_idx;
		logic [FIELD_W-1:0] fetch_row;
		logic               eol;
		logic               eof;
	} line_meta_t;

	function automatic logic [PIX_W-1:0] half_sum(input logic [PIX_W-1:0] x,
		input logic [PIX_W-1:0] y);
		return (x >> 1) + (y >> 1);
	endfunction

endpackage

/* hw/rtl/rgb565_upscale_320_to_800x480_top.sv */
// ----------------------------------------------------------------------------
// rgb565_upscale_320_to_800x480_top
// RGB565 2.5x horizontal upscaler with averaging and vertical row stepping.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word of four source pixels A,B,C,D, A in bits 15:0.
// Output stream (m_*): five words per input word, two pixels each:
//   A A, avg(A,B) B, B C, C avg(C,D), D D, with line and index tags and the
//   source row the next input word must come from. tlast marks end of line,
//   tuser carries last-of-item and end-of-frame.
// APB port: register 0 is the source height (0..480, larger writes saturate).
// An accepted word waits in the input register until the output register is
// free, and is then loaded into the output register, which drives its first
// output word. The output port delivers one word per cycle while m_tready is
// high, and a new input word is taken while the previous item's words are
// still being sent.
// Reset clears the line, group and row counters and sets height to 240.
// When m_tready is low the output word holds and, once the input register is
// full, s_tready drops.
// ----------------------------------------------------------------------------
module rgb565_upscale_320_to_800x480_top import rgbup_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // pixel_a, pixel_b, pixel_c, pixel_d
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // out_word, out_line, out_word_index, fetch_row
	output logic [USER_W-1:0]     m_tuser,   // last_of_item, end_of_frame
	output logic                  m_tlast,   // end_of_line
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic                in_valid_s1;
	logic [IN_W-1:0]     in_data_s1;
	logic                free, load;
	logic [HEIGHT_W-1:0] source_height;
	word_vec_t           words;
	line_meta_t          meta;

	assign load     = in_valid_s1 && free;
	assign s_tready = !in_valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_data_s1 <= s_tdata;
		end
	end

	rgbup_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.source_height (source_height)
	);

	rgbup_words u_words (
		.pixels (in_data_s1),
		.words  (words)
	);

	rgbup_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (load),
		.source_height (source_height),
		.meta          (meta)
	);

	rgbup_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.words    (words),
		.meta     (meta),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* hw/rtl/rgbup_cfg.sv */
// ----------------------------------------------------------------------------
// rgbup_cfg
// APB register block holding the source height, saturated on write.
// ----------------------------------------------------------------------------
module rgbup_cfg import rgbup_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [HEIGHT_W-1:0]   source_height
);

	logic                wr_en;
	logic                hit;
	logic [HEIGHT_W-1:0] wr_val;
	logic [HEIGHT_W-1:0] height_q;

	assign pready = 1'b1;
	assign hit    = (paddr[APB_ADDR_W-1] == REG_SOURCE_HEIGHT);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_comb begin
		wr_val = pwdata[HEIGHT_W-1:0];
		if (int'(wr_val) > OUT_LINES) begin
			wr_val = HEIGHT_W'(OUT_LINES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			height_q <= wr_val;
		end
	end

	assign prdata        = hit ? APB_DATA_W'(height_q) : '0;
	assign source_height = height_q;

endmodule

/* hw/rtl/rgbup_words.sv */
// ----------------------------------------------------------------------------
// rgbup_words
// Masks the four source pixels and builds the five output pixel pairs.
// ----------------------------------------------------------------------------
module rgbup_words import rgbup_pkg::*; (
	input  logic [IN_W-1:0] pixels,
	output word_vec_t       words
);

	logic [PIX_W-1:0] a, b, c, d;

	// clearing each channel's lsb keeps the halved sum from carrying across
	assign a = pixels[0*PIX_W +: PIX_W] & PIX_MASK;
	assign b = pixels[1*PIX_W +: PIX_W] & PIX_MASK;
	assign c = pixels[2*PIX_W +: PIX_W] & PIX_MASK;
	assign d = pixels[3*PIX_W +: PIX_W] & PIX_MASK;

	assign words[0] = {a, a};
	assign words[1] = {b, half_sum(a, b)};
	assign words[2] = {c, b};
	assign words[3] = {half_sum(c, d), c};
	assign words[4] = {d, d};

endmodule

/* hw/rtl/rgbup_seq.sv */
// ----------------------------------------------------------------------------
// rgbup_seq
// Group, line and source-row counters; row accumulator for vertical scaling.
// ----------------------------------------------------------------------------
module rgbup_seq import rgbup_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [HEIGHT_W-1:0] source_height,
	output line_meta_t          meta
);

	logic [GROUP_W-1:0] group_q;
	logic [LINE_W-1:0]  line_q;
	logic [LINE_W-1:0]  acc_q;
	logic [LINE_W-1:0]  row_q;

	logic               eol, eof, wrap;
	logic [SUM_W-1:0]   sum;
	logic [LINE_W-1:0]  acc_d;
	logic [LINE_W-1:0]  row_d;

	assign eol  = (int'(group_q) == GROUPS_PER_LINE - 1);
	assign eof  = eol && (int'(line_q) == OUT_LINES - 1);
	assign sum  = SUM_W'(acc_q) + SUM_W'(source_height);
	assign wrap = (int'(sum) >= OUT_LINES);

	always_comb begin
		acc_d = acc_q;
		row_d = row_q;
		if (eol) begin
			if (eof) begin
				acc_d = '0;
				row_d = '0;
			end else if (wrap) begin
				acc_d = LINE_W'(sum - SUM_W'(OUT_LINES));
				row_d = row_q + 1'b1;
			end else begin
				acc_d = LINE_W'(sum);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			line_q  <= '0;
			acc_q   <= '0;
			row_q   <= '0;
		end else if (advance) begin
			acc_q <= acc_d;
			row_q <= row_d;
			if (eol) begin
				group_q <= '0;
				line_q  <= eof ? '0 : line_q + 1'b1;
			end else begin
				group_q <= group_q + 1'b1;
			end
		end
	end

	assign meta.line      = FIELD_W'(line_q);
	assign meta.base_idx  = FIELD_W'(32'(group_q) * 32'(NUM_WORDS));
	assign meta.fetch_row = FIELD_W'(row_d);
	assign meta.eol       = eol;
	assign meta.eof       = eof;

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(line_q) < OUT_LINES)
		else $error("line counter out of range");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(acc_q) < OUT_LINES)
		else $error("row accumulator out of range");

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eof) |=> (line_q == '0 && acc_q == '0 && row_q == '0 && group_q == '0))
		else $error("frame end did not clear counters");

endmodule

/* hw/rtl/rgbup_out.sv */
// ----------------------------------------------------------------------------
// rgbup_out
// Output register: holds one item's five words and shifts them onto the bus.
// ----------------------------------------------------------------------------
module rgbup_out import rgbup_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  word_vec_t         words,
	input  line_meta_t        meta,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // out_word, out_line, out_word_index, fetch_row
	output logic [USER_W-1:0] m_tuser,   // last_of_item, end_of_frame
	output logic              m_tlast    // end_of_line
);

	logic               valid_q;
	logic [WCNT_W-1:0]  cnt_q;
	word_vec_t          word_q;
	logic [FIELD_W-1:0] idx_q;
	line_meta_t         meta_q;
	logic               take, last;

	assign last = (cnt_q == LAST_WORD);
	assign take = valid_q && m_tready;
	assign free = !valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end
			cnt_q <= last ? '0 : cnt_q + 1'b1;
		end
	end

	// payload: shift line, the word on the bus always sits in slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= words;
			idx_q  <= meta.base_idx;
			meta_q <= meta;
		end else if (take) begin
			for (int i = 0; i < NUM_WORDS - 1; i++) begin
				word_q[i] <= word_q[i+1];
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_W'({meta_q.fetch_row, idx_q, meta_q.line, word_q[0]});
	assign m_tuser  = {last && meta_q.eof, last};
	assign m_tlast  = last && meta_q.eol;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (cnt_q <= LAST_WORD))
		else $error("word counter past last word");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last) |=> (valid_q && cnt_q == $past(cnt_q) + 1'b1))
		else $error("word counter did not advance");

	a_no_early_load: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !(take && last)) |-> !load)
		else $error("item loaded over unsent words");

endmodule

/* test/upscale_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// upscale_checker
// Watches the pixel, output and APB channels of the RGB565 upscaler, works
// out the five output words of every accepted pixel group and compares each
// output word with the oldest one still owed.
// ----------------------------------------------------------------------------
module upscale_checker import rgbup_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // pixel_a, pixel_b, pixel_c, pixel_d
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_W-1:0]      m_tdata,   // out_word, out_line, out_word_index, fetch_row
	input  logic [USER_W-1:0]     m_tuser,   // last_of_item, end_of_frame
	input  logic                  m_tlast,   // end_of_line
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    pending,
	output int                    errors
);

	localparam int PAD_LSB = WORD_W + 3 * FIELD_W;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [FIELD_W-1:0] line;
		logic [FIELD_W-1:0] index;
		logic [FIELD_W-1:0] row;
		logic               last_item;
		logic               eol;
		logic               eof;
	} upscaled_word_t;

	upscaled_word_t expected_words[$];

	// scaler state as the block should hold it
	int height   = HEIGHT_RESET;
	int grp      = 0;
	int line_cnt = 0;
	int acc      = 0;
	int src_row  = 0;

	initial begin
		pending = 0;
		errors  = 0;
	end

	task automatic predict_group(input logic [IN_W-1:0] px);
		logic [PIX_W-1:0]  a, b, c, d, ab, cd;
		logic [WORD_W-1:0] w [NUM_WORDS];
		logic              eol, eof;
		int                line_now, base, sum;
		upscaled_word_t    e;
		a = px[0*PIX_W +: PIX_W] & PIX_MASK;
		b = px[1*PIX_W +: PIX_W] & PIX_MASK;
		c = px[2*PIX_W +: PIX_W] & PIX_MASK;
		d = px[3*PIX_W +: PIX_W] & PIX_MASK;
		// masking clears each channel's lsb, so halves add without carry across
		ab = (a >> 1) + (b >> 1);
		cd = (c >> 1) + (d >> 1);
		w[0] = {a, a};
		w[1] = {b, ab};
		w[2] = {c, b};
		w[3] = {cd, c};
		w[4] = {d, d};
		line_now = line_cnt;
		base     = grp * NUM_WORDS;
		eol      = (grp + 1 >= GROUPS_PER_LINE);
		eof      = eol && (line_cnt + 1 >= OUT_LINES);
		if (eol) begin
			grp = 0;
			if (eof) begin
				line_cnt = 0;
				acc      = 0;
				src_row  = 0;
			end else begin
				line_cnt++;
				sum = acc + height;
				if (sum >= OUT_LINES) begin
					sum -= OUT_LINES;
					src_row++;
				end
				acc = sum;
			end
		end else begin
			grp++;
		end
		for (int k = 0; k < NUM_WORDS; k++) begin
			e.word      = w[k];
			e.line      = FIELD_W'(line_now);
			e.index     = FIELD_W'(base + k);
			e.row       = FIELD_W'(src_row);
			e.last_item = (k == NUM_WORDS - 1);
			e.eol       = (k == NUM_WORDS - 1) && eol;
			e.eof       = (k == NUM_WORDS - 1) && eof;
			expected_words.push_back(e);
		end
	endtask

	task automatic log_error(input string what, input upscaled_word_t want,
		input upscaled_word_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: want %h l%0d i%0d r%0d %b%b%b, got %h l%0d i%0d r%0d %b%b%b",
				$realtime, what,
				want.word, want.line, want.index, want.row,
				want.last_item, want.eol, want.eof,
				got.word, got.line, got.index, got.row,
				got.last_item, got.eol, got.eof);
	endtask

	always @(posedge clk) begin : watch
		upscaled_word_t got, want;
		if (!arst_n) begin
			height   = HEIGHT_RESET;
			grp      = 0;
			line_cnt = 0;
			acc      = 0;
			src_row  = 0;
			expected_words.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr[APB_ADDR_W-1:2] == REG_SOURCE_HEIGHT)
				height = (pwdata[HEIGHT_W-1:0] > OUT_LINES) ? OUT_LINES
					: int'(pwdata[HEIGHT_W-1:0]);
			// output first, so a word can never match the group taken at this edge
			if (m_tvalid && m_tready) begin
				got.word      = m_tdata[0 +: WORD_W];
				got.line      = m_tdata[WORD_W +: FIELD_W];
				got.index     = m_tdata[WORD_W + FIELD_W +: FIELD_W];
				got.row       = m_tdata[WORD_W + 2 * FIELD_W +: FIELD_W];
				got.last_item = m_tuser[0];
				got.eof       = m_tuser[1];
				got.eol       = m_tlast;
				if (expected_words.size() == 0) begin
					log_error("unexpected word", '0, got);
				end else begin
					want = expected_words.pop_front();
					if (got !== want)
						log_error("word differs", want, got);
					else if (m_tdata[OUT_W-1:PAD_LSB] !== '0)
						log_error("tdata pad not zero", want, got);
				end
			end
			if (s_tvalid && s_tready)
				predict_group(s_tdata);
			pending <= expected_words.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the RGB565 2.5x upscaler with directed and random pixel groups under
// random stalls on both streams, steps the source height through its range
// over APB between phases, and runs short stretches at full rate with a
// height change between them. Checking is done by upscale_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import rgbup_pkg::*;

	localparam real TIMEOUT_NS   = 10_000_000.0;

	// second word slot of the APB map has no register behind it
	localparam logic REG_HOLE = 1'b1;
	localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT = {REG_SOURCE_HEIGHT, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_HOLE   = {REG_HOLE, 2'b00};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic [USER_W-1:0]     m_tuser;
	logic                  m_tlast;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int pending;
	int errors;
	int groups_sent = 0;
	bit stall_on    = 1'b1;
	int rx_hold     = 0;
	int rx_calm     = 0;

	logic [IN_W-1:0] directed_groups[$];

	rgb565_upscale_320_to_800x480_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	upscale_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.pending(pending), .errors(errors)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// output side: a random wait after each word, broken by calm stretches
	always @(posedge clk) begin : rx_pace
		int wait_cycles;
		wait_cycles = 0;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rx_calm > 0)
					rx_calm <= rx_calm - 1;
				else if (stall_on && $urandom_range(0, 7) == 0)
					rx_calm <= $urandom_range(8, 30);
				else if (stall_on)
					wait_cycles = $urandom_range(0, 6);
				rx_hold <= wait_cycles;
			end else if (rx_hold > 0) begin
				wait_cycles = rx_hold - 1;
				rx_hold <= wait_cycles;
			end
			m_tready <= (wait_cycles == 0);
		end
	end

	task automatic send_group(input logic [IN_W-1:0] px, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		groups_sent++;
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] rand_group();
		return {rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel()};
	endfunction

	task automatic run_random(input int n);
		bit calm;
		calm = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % 10 == 0)
				calm = ($urandom_range(0, 2) == 0);
			send_group(rand_group(), calm ? 0 : $urandom_range(0, 6));
		end
	endtask

	// full-rate stream up to a given group count from reset
	task automatic sweep_to(input int target);
		while (groups_sent < target)
			send_group(rand_group(), 0);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		directed_groups = '{
			64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hF7DE_F7DE_F7DE_F7DE, 64'h0821_0821_0821_0821,
			64'h0000_0000_0000_FFFF, 64'h0000_0000_FFFF_0000,
			64'h0000_FFFF_0000_0000, 64'hFFFF_0000_0000_0000,
			64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA,
			64'hF800_07E0_001F_F800, 64'h001F_F800_07E0_001F,
			64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF,
			64'h8000_0001_8000_0001, 64'h7FFF_FFFE_7FFF_FFFE
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset height, pixel extremes and channel patterns
		foreach (directed_groups[i])
			send_group(directed_groups[i], $urandom_range(0, 6));
		run_random(4);
		settle();

		reg_write(ADDR_HOLE, 32'h0000_0009);
		reg_write(ADDR_HEIGHT, 32'd1);
		run_random(30);
		settle();

		// zero height: the row never advances
		reg_write(ADDR_HEIGHT, 32'd0);
		run_random(25);
		settle();

		// above range, saturates to a full-height source
		reg_write(ADDR_HEIGHT, 32'h0000_03FF);
		run_random(25);
		settle();

		// full rate, height changed between stretches
		stall_on = 1'b0;
		reg_write(ADDR_HEIGHT, 32'd479);
		sweep_to(groups_sent + 20);
		settle();
		reg_write(ADDR_HEIGHT, 32'hFFFF_FE25);
		sweep_to(groups_sent + 20);
		settle();

		stall_on = 1'b1;
		reg_write(ADDR_HEIGHT, 32'd480);
		run_random(20);
		settle();

		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/rgbup_pkg.sv
hw/rtl/rgbup_cfg.sv
hw/rtl/rgbup_words.sv
hw/rtl/rgbup_seq.sv
hw/rtl/rgbup_out.sv
hw/rtl/rgb565_upscale_320_to_800x480_top.sv
test/upscale_checker.sv
test/tb_top.sv
